// ----- hdl/cfx_pkg.sv -----
// shared types, constants and gain-table function for the crossfader
`timescale 1ns / 1ps
package cfx_pkg;

   localparam int unsigned MAX_TRACKS_DEF = 16;
   localparam int unsigned PHASE_BITS_DEF = 10;

   localparam int unsigned ID_W     = 32;
   localparam int unsigned VOL_W    = 16;
   localparam int unsigned AMOUNT_W = 24;
   localparam int unsigned ELAPSED_W = 25;

   localparam logic [VOL_W-1:0] Q15_ONE = 16'h8000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // command codes on the request channel
   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_XFER = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_VOLUME = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_XFER,
      OP_TICK,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     track_key;
      logic [VOL_W-1:0]    base_level;
      logic [AMOUNT_W-1:0] time_amount;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REPLY,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_TICK,
      ST_DIV,
      ST_GAIN,
      ST_TRK_RD,
      ST_TRK_MUL,
      ST_TRK_OUT
   } back_state_type;

   // sin(j / 2^pb * pi/2) in q1.15, seven-term taylor series in q2.30
   function automatic logic [VOL_W-1:0] sine_q15(input int unsigned j,
                                                 input int unsigned pb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      x    = (longint'(j) * HALF_PI_Q30) >> pb;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;   sum = sum - term;
      term = ((term * x2) >> 30) / 20;  sum = sum + term;
      term = ((term * x2) >> 30) / 42;  sum = sum - term;
      term = ((term * x2) >> 30) / 72;  sum = sum + term;
      term = ((term * x2) >> 30) / 110; sum = sum - term;
      term = ((term * x2) >> 30) / 156; sum = sum + term;
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return r[VOL_W-1:0];
   endfunction

endpackage

// ----- hdl/cfx_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface cfx_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] track_key;
   logic [15:0] base_level;
   logic [23:0] time_amount;
   modport source(output valid, cmd, track_key, base_level, time_amount, input ready);
   modport sink(input valid, cmd, track_key, base_level, time_amount, output ready);
endinterface

interface cfx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] out_track_id;
   logic [15:0] volume;
   logic        last;
   modport source(output valid, result_kind, out_track_id, volume, last, input ready);
   modport sink(input valid, result_kind, out_track_id, volume, last, output ready);
endinterface

// ----- hdl/cfx_ram.sv -----
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module cfx_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hdl/cfx_front.sv -----
// front end: takes requests, decodes them and queues them for the back end
`timescale 1ns / 1ps
module cfx_front import cfx_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cfx_req_if.sink  req_ch,
   output logic     q_valid,
   input  logic     q_ready,
   output item_type q_item
);
   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   item_type   dec;
   logic       push, pop;

   // decode and clamp base volume to one
   always_comb begin
      case (req_ch.cmd)
         CMD_ADD:  dec.op = OP_ADD;
         CMD_XFER: dec.op = OP_XFER;
         CMD_TICK: dec.op = OP_TICK;
         default:  dec.op = OP_BAD;
      endcase
      dec.track_key   = req_ch.track_key;
      dec.base_level  = (req_ch.base_level > Q15_ONE) ? Q15_ONE : req_ch.base_level;
      dec.time_amount = req_ch.time_amount;
   end

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign q_valid = (fill_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

// ----- hdl/cfx_div.sv -----
// iterative restoring divider for the fade phase, one quotient bit a cycle
`timescale 1ns / 1ps
module cfx_div import cfx_pkg::*; #(
   parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [AMOUNT_W-1:0]   dividend,
   input  logic [AMOUNT_W-1:0]   divisor,
   output logic                  done,
   output logic [PHASE_BITS-1:0] quot
);
   localparam int unsigned SW = $clog2(PHASE_BITS + 1);

   logic [AMOUNT_W-1:0]   rem_ff, rem_in;
   logic [PHASE_BITS-1:0] quot_ff, quot_in;
   logic [SW-1:0]         step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [AMOUNT_W:0]     rem2;
   logic                  ge;

   always_comb begin
      rem2 = {rem_ff, 1'b0};
      ge = (rem2 >= {1'b0, divisor});
      rem_in = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         quot_in = '0;
         step_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? AMOUNT_W'(rem2 - {1'b0, divisor}) : rem2[AMOUNT_W-1:0];
         quot_in = {quot_ff[PHASE_BITS-2:0], ge};
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(PHASE_BITS - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ----- hdl/cfx_back.sv -----
// back end: track table, fade state, phase and gain, per-track volume results
`timescale 1ns / 1ps
module cfx_back import cfx_pkg::*; #(
   parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF,
   parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   output logic     q_ready,
   input  item_type q_item,
   cfx_rsp_if.source rsp_ch
);
   localparam int unsigned IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1);
   localparam int unsigned TAB_DEPTH = (1 << PHASE_BITS) + 1;
   localparam int unsigned TAB_W = PHASE_BITS + 1;

   typedef logic [VOL_W-1:0] tab_type [TAB_DEPTH];

   function automatic tab_type build_tab();
      tab_type t;
      for (int j = 0; j < TAB_DEPTH; j++) begin
         t[j] = sine_q15(j, PHASE_BITS);
      end
      return t;
   endfunction

   localparam tab_type SINE_TAB = build_tab();

   back_state_type state_ff, state_in;
   item_type            item_ff, item_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    cur_idx_ff, cur_idx_in;
   logic                cur_vld_ff, cur_vld_in;
   logic [IDX_W-1:0]    tgt_idx_ff, tgt_idx_in;
   logic                tgt_vld_ff, tgt_vld_in;
   logic                fading_ff, fading_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [AMOUNT_W-1:0] duration_ff, duration_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [1:0]          reply_kind_ff, reply_kind_in;
   logic                mid_ff, mid_in;
   logic [PHASE_BITS-1:0] k_ff, k_in;
   logic [VOL_W-1:0]    gin_ff, gin_in;
   logic [VOL_W-1:0]    gout_ff, gout_in;
   logic [31:0]         prod_ff, prod_in;
   logic [ID_W-1:0]     tid_ff, tid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [VOL_W-1:0]    rsp_vol_ff, rsp_vol_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                full;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ID_W-1:0]     id_rd;
   logic [VOL_W-1:0]    vol_rd;
   logic                div_start;
   logic                div_done;
   logic [PHASE_BITS-1:0] div_quot;
   logic [ELAPSED_W-1:0] tick_sum;
   logic                idx_is_last;
   logic                hit_cur;
   logic                hit_tgt;
   logic [VOL_W-1:0]    gain;
   logic [31:0]         rounded;

   cfx_ram #(.WIDTH(ID_W), .DEPTH(MAX_TRACKS)) u_id_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (q_item.track_key),
      .raddr (ram_raddr),
      .rdata (id_rd)
   );

   cfx_ram #(.WIDTH(VOL_W), .DEPTH(MAX_TRACKS)) u_vol_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (q_item.base_level),
      .raddr (ram_raddr),
      .rdata (vol_rd)
   );

   cfx_div #(.PHASE_BITS(PHASE_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tick_sum[AMOUNT_W-1:0]),
      .divisor  (duration_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign full = (count_ff == CNT_W'(MAX_TRACKS));
   assign ram_raddr = idx_ff[IDX_W-1:0];
   assign tick_sum = elapsed_ff + ELAPSED_W'(item_ff.time_amount);
   assign idx_is_last = (idx_ff + CNT_W'(1) == count_ff);
   assign hit_cur = cur_vld_ff && (idx_ff[IDX_W-1:0] == cur_idx_ff);
   assign hit_tgt = mid_ff && tgt_vld_ff && (idx_ff[IDX_W-1:0] == tgt_idx_ff);
   assign rounded = prod_ff + 32'd16384;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_XFER: begin
                     if (q_item.time_amount == '0 || count_ff == '0) begin
                        state_in = ST_REPLY;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  OP_TICK: state_in = ST_TICK;
                  default: state_in = ST_REPLY;
               endcase
            end
         end
         ST_REPLY: if (out_free) state_in = ST_IDLE;
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (id_rd == item_ff.track_key || idx_is_last) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_TICK: begin
            if (fading_ff && tick_sum < ELAPSED_W'(duration_ff)) begin
               state_in = ST_DIV;
            end else if (count_ff == '0) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_TRK_RD;
            end
         end
         ST_DIV: if (div_done) state_in = ST_GAIN;
         ST_GAIN: state_in = ST_TRK_RD;
         ST_TRK_RD: state_in = ST_TRK_MUL;
         ST_TRK_MUL: state_in = ST_TRK_OUT;
         ST_TRK_OUT: begin
            if (out_free) begin
               state_in = idx_is_last ? ST_IDLE : ST_TRK_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in = item_ff;
      count_in = count_ff;
      cur_idx_in = cur_idx_ff;
      cur_vld_in = cur_vld_ff;
      tgt_idx_in = tgt_idx_ff;
      tgt_vld_in = tgt_vld_ff;
      fading_in = fading_ff;
      elapsed_in = elapsed_ff;
      duration_in = duration_ff;
      idx_in = idx_ff;
      reply_kind_in = reply_kind_ff;
      mid_in = mid_ff;
      k_in = k_ff;
      gin_in = gin_ff;
      gout_in = gout_ff;
      prod_in = prod_ff;
      tid_in = tid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_id_in = rsp_id_ff;
      rsp_vol_in = rsp_vol_ff;
      rsp_last_in = rsp_last_ff;
      q_ready = 1'b0;
      ram_we = 1'b0;
      div_start = 1'b0;
      gain = '0;
      case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               item_in = q_item;
               idx_in = '0;
               reply_kind_in = KIND_REJECT;
               if (q_item.op == OP_ADD && !full) begin
                  ram_we = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  reply_kind_in = KIND_ACCEPT;
                  if (!cur_vld_ff) begin
                     cur_vld_in = 1'b1;
                     cur_idx_in = '0;
                  end
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = reply_kind_ff;
               rsp_id_in = '0;
               rsp_vol_in = '0;
               rsp_last_in = 1'b1;
            end
         end
         ST_SCAN_CMP: begin
            if (id_rd == item_ff.track_key) begin
               if (!hit_cur) begin
                  reply_kind_in = KIND_ACCEPT;
                  tgt_idx_in = idx_ff[IDX_W-1:0];
                  tgt_vld_in = 1'b1;
                  duration_in = item_ff.time_amount;
                  elapsed_in = '0;
                  fading_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_TICK: begin
            mid_in = 1'b0;
            reply_kind_in = KIND_EMPTY;
            if (fading_ff) begin
               elapsed_in = tick_sum;
               if (tick_sum >= ELAPSED_W'(duration_ff)) begin
                  fading_in = 1'b0;
                  cur_idx_in = tgt_idx_ff;
                  cur_vld_in = tgt_vld_ff;
                  tgt_vld_in = 1'b0;
                  tgt_idx_in = '0;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_done) k_in = div_quot;
         end
         ST_GAIN: begin
            gin_in = SINE_TAB[TAB_W'(k_ff)];
            gout_in = SINE_TAB[TAB_W'(1 << PHASE_BITS) - TAB_W'(k_ff)];
            mid_in = 1'b1;
         end
         ST_TRK_MUL: begin
            // a steady current track passes its base through a unity gain
            if (hit_cur) begin
               gain = mid_ff ? gout_ff : Q15_ONE;
            end else if (hit_tgt) begin
               gain = gin_ff;
            end
            prod_in = 32'(vol_rd) * 32'(gain);
            tid_in = id_rd;
         end
         ST_TRK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_VOLUME;
               rsp_id_in = tid_ff;
               rsp_vol_in = rounded[VOL_W+14:15];
               rsp_last_in = idx_is_last;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_idx_ff   <= '0;
         cur_vld_ff   <= 1'b0;
         tgt_idx_ff   <= '0;
         tgt_vld_ff   <= 1'b0;
         fading_ff    <= 1'b0;
         elapsed_ff   <= '0;
         duration_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_idx_ff   <= cur_idx_in;
         cur_vld_ff   <= cur_vld_in;
         tgt_idx_ff   <= tgt_idx_in;
         tgt_vld_ff   <= tgt_vld_in;
         fading_ff    <= fading_in;
         elapsed_ff   <= elapsed_in;
         duration_ff  <= duration_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      reply_kind_ff <= reply_kind_in;
      mid_ff        <= mid_in;
      k_ff          <= k_in;
      gin_ff        <= gin_in;
      gout_ff       <= gout_in;
      prod_ff       <= prod_in;
      tid_ff        <= tid_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_vol_ff    <= rsp_vol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_kind  = rsp_kind_ff;
   assign rsp_ch.out_track_id = rsp_id_ff;
   assign rsp_ch.volume       = rsp_vol_ff;
   assign rsp_ch.last         = rsp_last_ff;
endmodule

// ----- hdl/equal_power_track_crossfader.sv -----
// top level of the equal-power track crossfader
`timescale 1ns / 1ps
// Equal-power crossfader over a table of up to MAX_TRACKS tracks (id plus
// q1.15 base volume). Requests: add a track, start a fade towards a track id,
// or tick the fade timer; a tick returns one volume per track (an empty
// result when the table is empty), base*cos for the outgoing track and
// base*sin for the incoming one while a fade runs, the current track's base
// otherwise, zero for the rest, with last set on the final one. A two-entry
// queue sits between the front end and the sequencer, so requests keep
// flowing while a result waits in the output register. An add writes the
// table; a transition scans the table entries for the id; a tick runs the
// phase divider, one quotient bit per cycle, and the gain lookup while a
// fade runs, then reads the ram, multiplies and outputs each track in turn.
module equal_power_track_crossfader import cfx_pkg::*; #(
   parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF,
   parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cfx_req_if.sink   req_ch,
   cfx_rsp_if.source rsp_ch
);
   // decoded request queue between front and back
   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   // front end: decode, clamp base volume, queue
   cfx_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   // back end: table, fade timer, divider, gain table, result sequencing
   cfx_back #(
      .MAX_TRACKS (MAX_TRACKS),
      .PHASE_BITS (PHASE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item),
      .rsp_ch  (rsp_ch)
   );
endmodule
